FILE: src/video_test_pattern_generator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the video test pattern generator
// Clocked, reset-gated property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef VIDEO_TEST_PATTERN_GENERATOR_ASSERT_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_ASSERT_SVH

// Same-cycle implication
`define VTPG_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("video test pattern generator check failed");

// Next-cycle implication
`define VTPG_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("video test pattern generator check failed");

`endif

FILE: src/vtpg_pkg.sv
// ----------------------------------------------------------------------------
// vtpg_pkg
// Shared types, register map and constants of the test pattern generator.
// ----------------------------------------------------------------------------
package vtpg_pkg;

    // Register and field widths
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 12;
    localparam int MODE_W       = 2;
    localparam int STEP_W       = 25;
    localparam int BYTE_W       = 8;
    localparam int COORD_W      = 11;
    localparam int BAR_IDX_W    = 4;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Parameter defaults
    localparam int DEF_MAX_WIDTH     = 2048;
    localparam int DEF_MAX_HEIGHT    = 2048;
    localparam int DEF_FRACTION_BITS = 16;

    // Register indexes (byte address / 4)
    typedef logic [APB_ADDR_W-3:0] reg_idx_t;
    localparam reg_idx_t REG_FRAME_WIDTH  = 3'd0;
    localparam reg_idx_t REG_FRAME_HEIGHT = 3'd1;
    localparam reg_idx_t REG_PATTERN_MODE = 3'd2;
    localparam reg_idx_t REG_COLUMN_STEP  = 3'd3;
    localparam reg_idx_t REG_ROW_STEP     = 3'd4;

    // Pattern modes
    typedef logic [MODE_W-1:0] mode_t;
    localparam mode_t MODE_RAMP        = 2'd0;
    localparam mode_t MODE_BARS        = 2'd1;
    localparam mode_t MODE_BARS_SQUARE = 2'd2;

    // Register reset values
    localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam mode_t                   RST_PATTERN_MODE = MODE_BARS;
    localparam logic [STEP_W-1:0]       RST_COLUMN_STEP  = 25'd184365;
    localparam logic [STEP_W-1:0]       RST_ROW_STEP     = 25'd69905;

    // Color bars
    localparam logic [BAR_IDX_W-1:0] BAR_FIRST      = 4'd1;
    localparam logic [BAR_IDX_W-1:0] BAR_LAST       = 4'd7;
    localparam logic [BAR_IDX_W-1:0] BAR_WHITE      = 4'd8;
    localparam logic [BAR_IDX_W-1:0] BAR_RED_MASK   = 4'b0001;
    localparam logic [BAR_IDX_W-1:0] BAR_BLUE_MASK  = 4'b0010;
    localparam logic [BAR_IDX_W-1:0] BAR_GREEN_MASK = 4'b0100;

    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

    // Half size of the center square
    localparam int SQUARE_HALF = 50;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  frame_width;
        logic [HEIGHT_REG_W-1:0] frame_height;
        mode_t                   pattern_mode;
        logic [STEP_W-1:0]       column_step;
        logic [STEP_W-1:0]       row_step;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] green;
    } rgb_t;

endpackage

FILE: src/video_test_pattern_generator.sv
// ----------------------------------------------------------------------------
// video_test_pattern_generator
// Raster-order test pattern source: ramp grid, color bars, bars with square.
// An accepted pixel goes to the output register, or to the skid register while the output is stalled.
// Throughput: one pixel per cycle while the pixel channel is not stalled; all per-pixel
// work sits between the state registers and the output register, with a skid register behind the output.
// Reset: position (0,0), ramps restarted, registers at their defaults.
// ----------------------------------------------------------------------------
module video_test_pattern_generator
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // Request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  restart,
    // Pixel channel
    output logic                  pixel_valid,
    input  logic                  pixel_stall,
    output logic [BYTE_W-1:0]     byte_red,
    output logic [BYTE_W-1:0]     byte_blue,
    output logic [BYTE_W-1:0]     byte_green,
    output logic [COORD_W-1:0]    column,
    output logic [COORD_W-1:0]    line,
    output logic                  end_of_line,
    output logic                  end_of_frame
);

    localparam int F     = FRACTION_BITS;
    localparam int AW    = F + 10;
    localparam int BARW  = F + 8;
    localparam int SUMW  = ((AW > STEP_W + 1) ? AW : STEP_W + 1) + 1;
    localparam int BSUMW = ((BARW > STEP_W) ? BARW : STEP_W) + 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    localparam logic signed [AW-1:0]   FIX_ONE = {2'b01, {(AW-2){1'b0}}};
    localparam logic signed [SUMW-1:0] ACC_HI  = {{(SUMW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] ACC_LO  = {{(SUMW-AW+1){1'b1}}, {(AW-1){1'b0}}};

    typedef struct packed {
        rgb_t               rgb;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic               eol;
        logic               eof;
    } pixel_t;

    cfg_t cfg;

    // Raster and ramp state
    logic        [CW-1:0]        col_reg, col_next, col_eff;
    logic        [LW-1:0]        ln_reg, ln_next, ln_eff;
    logic signed [AW-1:0]        red_reg, red_next, red_eff, red_ramp;
    logic signed [AW-1:0]        blue_reg, blue_next, blue_eff, blue_ramp;
    logic signed [AW-1:0]        green_reg, green_next, green_eff, green_ramp;
    logic        [BARW-1:0]      bar_reg, bar_next, bar_eff, bar_ramp;
    logic        [BAR_IDX_W-1:0] idx_reg, idx_next, idx_eff, idx_ramp;

    logic [WW-1:0]    wc, i1, i2, i3;
    logic [HW-1:0]    hc;
    logic [CW-1:0]    wm1;
    logic [LW-1:0]    hm1;
    logic             eol, eof;
    logic [BSUMW-1:0] bar_sum;
    logic             bar_wrap;
    rgb_t             rgb;
    pixel_t           pix_new;

    // Output and skid stage
    pixel_t out_reg, skid_reg;
    logic   out_valid_reg, skid_valid_reg;
    logic   accept, slot_free;

    // Saturating add or subtract of a step on a ramp accumulator
    function automatic logic signed [AW-1:0] sat_step(
        input logic signed [AW-1:0] acc,
        input logic [STEP_W-1:0]    step,
        input logic                 sub
    );
        logic signed [SUMW-1:0] a;
        logic signed [SUMW-1:0] s;
        logic signed [SUMW-1:0] sum;
        a   = SUMW'(acc);
        s   = signed'(SUMW'(step));
        sum = sub ? (a - s) : (a + s);
        if (sum > ACC_HI)
            sum = ACC_HI;
        else if (sum < ACC_LO)
            sum = ACC_LO;
        return sum[AW-1:0];
    endfunction

    vtpg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // Clamp frame size to 1..MAX
    always_comb
    begin
        if (cfg.frame_width == '0)
            wc = WW'(1);
        else if (32'(cfg.frame_width) > MAX_WIDTH)
            wc = WW'(MAX_WIDTH);
        else
            wc = WW'(cfg.frame_width);

        if (cfg.frame_height == '0)
            hc = HW'(1);
        else if (32'(cfg.frame_height) > MAX_HEIGHT)
            hc = HW'(MAX_HEIGHT);
        else
            hc = HW'(cfg.frame_height);
    end

    assign wm1 = CW'(wc - WW'(1));
    assign hm1 = LW'(hc - HW'(1));

    // State seen by this pixel: restart forces the frame start values
    assign col_eff   = restart ? '0        : col_reg;
    assign ln_eff    = restart ? '0        : ln_reg;
    assign red_eff   = restart ? FIX_ONE   : red_reg;
    assign blue_eff  = restart ? '0        : blue_reg;
    assign green_eff = restart ? '0        : green_reg;
    assign bar_eff   = restart ? '0        : bar_reg;
    assign idx_eff   = restart ? BAR_FIRST : idx_reg;

    assign eol = col_eff >= wm1;
    assign eof = eol && (ln_eff >= hm1);

    // Quarter-width intervals of the horizontal ramp
    assign i1 = wc >> 2;
    assign i2 = i1 << 1;
    assign i3 = i1 + i2;

    always_comb
    begin
        if (WW'(col_eff) < i1)
        begin
            blue_ramp = '0;
            red_ramp  = sat_step(red_eff, cfg.column_step, 1'b1);
        end
        else if (WW'(col_eff) < i2)
        begin
            blue_ramp = sat_step(blue_eff, cfg.column_step, 1'b0);
            red_ramp  = sat_step(red_eff, cfg.column_step, 1'b0);
        end
        else if (WW'(col_eff) < i3)
        begin
            blue_ramp = sat_step(blue_eff, cfg.column_step, 1'b1);
            red_ramp  = sat_step(red_eff, cfg.column_step, 1'b1);
        end
        else
        begin
            blue_ramp = sat_step(blue_eff, cfg.column_step, 1'b0);
            red_ramp  = '0;
        end
    end

    // Bar accumulator: wraps at 256.0 and moves to the next bar, stopping at white
    assign bar_sum  = BSUMW'(bar_eff) + BSUMW'(cfg.column_step);
    assign bar_wrap = bar_sum[BSUMW-1:BARW] != '0;
    assign bar_ramp = bar_wrap ? '0 : bar_sum[BARW-1:0];
    assign idx_ramp = (bar_wrap && (idx_eff != BAR_WHITE)) ? idx_eff + 1'b1 : idx_eff;

    // Green rises over the top half of the frame and falls below it
    assign green_ramp = sat_step(green_eff, cfg.row_step, !(HW'(ln_eff) < (hc >> 1)));

    // Next raster state
    always_comb
    begin
        if (eof)
        begin
            col_next   = '0;
            ln_next    = '0;
            green_next = '0;
            red_next   = FIX_ONE;
            blue_next  = '0;
            bar_next   = '0;
            idx_next   = BAR_FIRST;
        end
        else if (eol)
        begin
            col_next   = '0;
            ln_next    = ln_eff + 1'b1;
            green_next = green_ramp;
            red_next   = FIX_ONE;
            blue_next  = '0;
            bar_next   = '0;
            idx_next   = BAR_FIRST;
        end
        else
        begin
            col_next   = col_eff + 1'b1;
            ln_next    = ln_eff;
            green_next = green_eff;
            red_next   = red_ramp;
            blue_next  = blue_ramp;
            bar_next   = bar_ramp;
            idx_next   = idx_ramp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            ln_reg    <= '0;
            red_reg   <= FIX_ONE;
            blue_reg  <= '0;
            green_reg <= '0;
            bar_reg   <= '0;
            idx_reg   <= BAR_FIRST;
        end
        else if (accept)
        begin
            col_reg   <= col_next;
            ln_reg    <= ln_next;
            red_reg   <= red_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            bar_reg   <= bar_next;
            idx_reg   <= idx_next;
        end
    end

    // Pixel color
    vtpg_color #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_color (
        .mode      (cfg.pattern_mode),
        .red_acc   (red_eff),
        .blue_acc  (blue_eff),
        .green_acc (green_eff),
        .bar_acc   (bar_eff),
        .bar_idx   (idx_eff),
        .col       (col_eff),
        .ln        (ln_eff),
        .width     (wc),
        .height    (hc),
        .rgb       (rgb)
    );

    assign pix_new.rgb    = rgb;
    assign pix_new.column = COORD_W'(col_eff);
    assign pix_new.line   = COORD_W'(ln_eff);
    assign pix_new.eol    = eol;
    assign pix_new.eof    = eof;

    // Handshake: skid register takes a pixel while the output is stalled
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign slot_free = !out_valid_reg || !pixel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= pix_new;
        end
        else if (accept)
        begin
            skid_reg <= pix_new;
        end
    end

    assign pixel_valid  = out_valid_reg;
    assign byte_red     = out_reg.rgb.red;
    assign byte_blue    = out_reg.rgb.blue;
    assign byte_green   = out_reg.rgb.green;
    assign column       = out_reg.column;
    assign line         = out_reg.line;
    assign end_of_line  = out_reg.eol;
    assign end_of_frame = out_reg.eof;

endmodule

FILE: src/vtpg_regs.sv
// ----------------------------------------------------------------------------
// vtpg_regs
// APB register file holding frame size, pattern mode and ramp steps.
// ----------------------------------------------------------------------------
module vtpg_regs
    import vtpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = paddr[APB_ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= RST_FRAME_WIDTH;
            cfg_reg.frame_height <= RST_FRAME_HEIGHT;
            cfg_reg.pattern_mode <= RST_PATTERN_MODE;
            cfg_reg.column_step  <= RST_COLUMN_STEP;
            cfg_reg.row_step     <= RST_ROW_STEP;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[WIDTH_REG_W-1:0];
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[HEIGHT_REG_W-1:0];
                REG_PATTERN_MODE: cfg_reg.pattern_mode <= pwdata[MODE_W-1:0];
                REG_COLUMN_STEP:  cfg_reg.column_step  <= pwdata[STEP_W-1:0];
                REG_ROW_STEP:     cfg_reg.row_step     <= pwdata[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg_reg.frame_height);
            REG_PATTERN_MODE: prdata = APB_DATA_W'(cfg_reg.pattern_mode);
            REG_COLUMN_STEP:  prdata = APB_DATA_W'(cfg_reg.column_step);
            REG_ROW_STEP:     prdata = APB_DATA_W'(cfg_reg.row_step);
            default:          prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/vtpg_color.sv
// ----------------------------------------------------------------------------
// vtpg_color
// Pixel color from the ramp accumulators, bar state and coordinates.
// ----------------------------------------------------------------------------
module vtpg_color
    import vtpg_pkg::*;
#(
    parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = DEF_MAX_HEIGHT,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  mode_t                            mode,
    input  logic signed [FRACTION_BITS+9:0]  red_acc,
    input  logic signed [FRACTION_BITS+9:0]  blue_acc,
    input  logic signed [FRACTION_BITS+9:0]  green_acc,
    input  logic        [FRACTION_BITS+7:0]  bar_acc,
    input  logic        [BAR_IDX_W-1:0]      bar_idx,
    input  logic [$clog2(MAX_WIDTH)-1:0]     col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]    ln,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]   width,
    input  logic [$clog2(MAX_HEIGHT+1)-1:0]  height,
    output rgb_t                             rgb
);

    localparam int AW = FRACTION_BITS + 10;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = ((WW > 7) ? WW : 7) + 1;
    localparam int YW = ((HW > 7) ? HW : 7) + 1;

    logic [BYTE_W-1:0] bar_lvl;
    rgb_t              bars;
    logic              in_square;
    logic [XW-1:0]     cx;
    logic [YW-1:0]     cy;
    logic [XW-1:0]     x;
    logic [YW-1:0]     y;

    // Ramp value to byte: negative gives 0, 256.0 and up gives 255
    function automatic logic [BYTE_W-1:0] to_byte(input logic signed [AW-1:0] v);
        if (v[AW-1])
            return '0;
        else if (v[AW-2])
            return BYTE_MAX;
        else
            return v[FRACTION_BITS+BYTE_W-1:FRACTION_BITS];
    endfunction

    // Center square bounds, written without subtraction so nothing wraps
    assign cx = XW'(width >> 1);
    assign cy = YW'(height >> 1);
    assign x  = XW'(col);
    assign y  = YW'(ln);
    assign in_square = (x + XW'(SQUARE_HALF) > cx) && (x < cx + XW'(SQUARE_HALF)) &&
                       (y + YW'(SQUARE_HALF) > cy) && (y < cy + YW'(SQUARE_HALF));

    // Bar color, white past the last bar
    always_comb
    begin
        bar_lvl = bar_acc[FRACTION_BITS+BYTE_W-1:FRACTION_BITS];
        if (bar_idx > BAR_LAST)
        begin
            bars = '{red: BYTE_MAX, blue: BYTE_MAX, green: BYTE_MAX};
        end
        else
        begin
            bars.red   = ((bar_idx & BAR_RED_MASK)   != '0) ? bar_lvl : '0;
            bars.blue  = ((bar_idx & BAR_BLUE_MASK)  != '0) ? bar_lvl : '0;
            bars.green = ((bar_idx & BAR_GREEN_MASK) != '0) ? bar_lvl : '0;
        end
    end

    // Mode select
    always_comb
    begin
        case (mode)
            MODE_RAMP:
            begin
                rgb.red   = to_byte(red_acc);
                rgb.blue  = to_byte(blue_acc);
                rgb.green = to_byte(green_acc);
            end
            MODE_BARS:
            begin
                rgb = bars;
            end
            MODE_BARS_SQUARE:
            begin
                if (in_square)
                    rgb = '{red: BYTE_MAX, blue: BYTE_MAX, green: '0};
                else
                    rgb = bars;
            end
            default:
            begin
                rgb = '0;
            end
        endcase
    end

endmodule

FILE: src/vtpg_checker.sv
// ----------------------------------------------------------------------------
// vtpg_checker
// Port-level checks of the test pattern generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "video_test_pattern_generator_assert.svh"

module vtpg_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_stall,
    input logic        restart,
    input logic        pixel_valid,
    input logic        pixel_stall,
    input logic [10:0] column,
    input logic [10:0] line,
    input logic        end_of_line,
    input logic        end_of_frame
);

    // A stalled pixel holds its position
    `VTPG_ASSERT_NEXT(a_pixel_hold, clk, rst_n, pixel_valid && pixel_stall, pixel_valid && $stable(column) && $stable(line) && $stable(end_of_line))

    // The last pixel of a frame also ends its line
    `VTPG_ASSERT_NOW(a_eof_is_eol, clk, rst_n, pixel_valid && end_of_frame, end_of_line)

    // Requests back up only when a pixel is already waiting
    `VTPG_ASSERT_NOW(a_stall_needs_pixel, clk, rst_n, !pixel_valid, !req_stall)

    // A restart with a free output shows pixel (0,0) next cycle
    `VTPG_ASSERT_NEXT(a_restart_origin, clk, rst_n, req_valid && !req_stall && restart && !(pixel_valid && pixel_stall), pixel_valid && column == 11'd0 && line == 11'd0)

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .restart      (restart),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .column       (column),
    .line         (line),
    .end_of_line  (end_of_line),
    .end_of_frame (end_of_frame)
);
